[rtl/rthsv_pkg.sv]
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: shared package
// Types, widths and the restoring-division step used by the divider stages.
// ----------------------------------------------------------------------------
`default_nettype none

package rthsv_pkg;

  // Quotient bits resolved in each divider stage.
  localparam int HUE_STEPS = 8;
  localparam int SAT_STEPS = 7;

  // Hue quotient carries one spare top bit, saturation one as well.
  localparam int HUE_QW = 2 * HUE_STEPS;
  localparam int SAT_QW = 2 * SAT_STEPS;

  // Packed widths of the stream payloads.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Hue sector chosen by the first channel equal to the maximum.
  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } rthsv_sector_t;

  // Working state of both dividers as it moves down the pipeline.
  typedef struct packed {
    logic [7:0]        hue_div;   // delta
    logic [7:0]        hue_rem;
    logic [HUE_QW-1:0] hue_num;   // numerator bits not yet consumed, MSB first
    logic [HUE_QW-1:0] hue_quo;
    logic [7:0]        sat_rem;
    logic [SAT_QW-1:0] sat_num;
    logic [SAT_QW-1:0] sat_quo;
    logic [7:0]        bright;    // max, also the saturation divisor
    logic              zero;      // grey or black: hue and saturation are zero
  } rthsv_div_t;

  // One restoring-division step: returns {quotient bit, new remainder}.
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
                                          input logic [7:0] dvs);
    logic [8:0] trial;
    logic [8:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      div_step = {1'b1, diff[7:0]};
    end else begin
      div_step = {1'b0, trial[7:0]};
    end
  endfunction

endpackage

`default_nettype wire

[rtl/rthsv_front.sv]
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Finds max, min and delta, picks the hue sector and forms both dividends.
// ----------------------------------------------------------------------------
`default_nettype none

module rthsv_front (
  input  wire logic [7:0]           red,
  input  wire logic [7:0]           green,
  input  wire logic [7:0]           blue,
  output rthsv_pkg::rthsv_div_t     div_init
);

  logic [7:0]               mx;
  logic [7:0]               mn;
  logic [7:0]               delta;
  rthsv_pkg::rthsv_sector_t sector;
  logic signed [11:0]       diff;
  logic signed [11:0]       tsum;
  logic [10:0]              tval;
  logic [14:0]              t15;
  logic [22:0]              hue_n;
  logic [19:0]              sat_n;

  // Largest and smallest channel.
  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    delta = mx - mn;
  end

  // Sector by the first channel that equals max, red first.
  always_comb begin
    if (red == mx) begin
      sector = rthsv_pkg::SEC_RED;
    end else if (green == mx) begin
      sector = rthsv_pkg::SEC_GREEN;
    end else begin
      sector = rthsv_pkg::SEC_BLUE;
    end
  end

  // Hue in sixths of a turn times delta: t = diff + k*delta, 0 <= t < 6*delta.
  always_comb begin
    unique case (sector)
      rthsv_pkg::SEC_RED: begin
        diff = $signed({4'b0, green}) - $signed({4'b0, blue});
        if (diff < 0) begin
          tsum = diff + $signed({4'b0, delta} * 12'd6);
        end else begin
          tsum = diff;
        end
      end
      rthsv_pkg::SEC_GREEN: begin
        diff = $signed({4'b0, blue}) - $signed({4'b0, red});
        tsum = diff + $signed({3'b0, delta, 1'b0});
      end
      default: begin
        diff = $signed({4'b0, red}) - $signed({4'b0, green});
        tsum = diff + $signed({2'b0, delta, 2'b0});
      end
    endcase
    tval = tsum[10:0];
  end

  // Hue dividend is t * 3840 = (t * 15) << 8; saturation dividend is delta << 12.
  always_comb begin
    t15   = {tval, 4'b0} - {4'b0, tval};
    hue_n = {t15, 8'b0};
    sat_n = {delta, 12'b0};
  end

  // Initial remainders take the dividend bits above the quotient width.
  always_comb begin
    div_init.hue_div = delta;
    div_init.hue_rem = {1'b0, hue_n[22:rthsv_pkg::HUE_QW]};
    div_init.hue_num = hue_n[rthsv_pkg::HUE_QW-1:0];
    div_init.hue_quo = '0;
    div_init.sat_rem = {2'b0, sat_n[19:rthsv_pkg::SAT_QW]};
    div_init.sat_num = sat_n[rthsv_pkg::SAT_QW-1:0];
    div_init.sat_quo = '0;
    div_init.bright  = mx;
    div_init.zero    = (delta == 8'd0);
  end

endmodule

`default_nettype wire

[rtl/rthsv_div_stage.sv]
// ----------------------------------------------------------------------------
// RGB to HSV divider stage
// Resolves a group of quotient bits of the hue and saturation divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module rthsv_div_stage (
  input  wire rthsv_pkg::rthsv_div_t div_in,
  output rthsv_pkg::rthsv_div_t      div_out
);

  logic [7:0]                      hrem;
  logic [7:0]                      srem;
  logic [rthsv_pkg::HUE_STEPS-1:0] hq;
  logic [rthsv_pkg::SAT_STEPS-1:0] sq;
  logic [8:0]                      hres;
  logic [8:0]                      sres;

  // Hue: one restoring step per numerator bit, most significant first.
  always_comb begin
    hrem = div_in.hue_rem;
    hq   = '0;
    hres = '0;
    for (int i = 0; i < rthsv_pkg::HUE_STEPS; i++) begin
      hres = rthsv_pkg::div_step(hrem, div_in.hue_num[rthsv_pkg::HUE_QW-1-i],
                                 div_in.hue_div);
      hrem = hres[7:0];
      hq[rthsv_pkg::HUE_STEPS-1-i] = hres[8];
    end
  end

  // Saturation: same steps with max as divisor.
  always_comb begin
    srem = div_in.sat_rem;
    sq   = '0;
    sres = '0;
    for (int i = 0; i < rthsv_pkg::SAT_STEPS; i++) begin
      sres = rthsv_pkg::div_step(srem, div_in.sat_num[rthsv_pkg::SAT_QW-1-i],
                                 div_in.bright);
      srem = sres[7:0];
      sq[rthsv_pkg::SAT_STEPS-1-i] = sres[8];
    end
  end

  // Shift the consumed bits out and the new quotient bits in.
  always_comb begin
    div_out         = div_in;
    div_out.hue_rem = hrem;
    div_out.hue_num = div_in.hue_num << rthsv_pkg::HUE_STEPS;
    div_out.hue_quo = {div_in.hue_quo[rthsv_pkg::HUE_QW-rthsv_pkg::HUE_STEPS-1:0], hq};
    div_out.sat_rem = srem;
    div_out.sat_num = div_in.sat_num << rthsv_pkg::SAT_STEPS;
    div_out.sat_quo = {div_in.sat_quo[rthsv_pkg::SAT_QW-rthsv_pkg::SAT_STEPS-1:0], sq};
  end

endmodule

`default_nettype wire

[rtl/rgb_to_hsv_pixel.sv]
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter
// Converts 8-bit RGB pixels to hue (1/64 degree), saturation (4096 = 1.0)
// and brightness in a three-stage pipeline.
//
//   Channel   Direction  Payload
//   s_*       in         tdata: red, green, blue (8 bits each)
//   m_*       out        tdata: hue (15), saturation (13), brightness (8), pad
//
// One pixel per clock sustained while m_tready is high; a pixel is registered in
// stages one, two and three before output valid. Stage one finds max, min and
// sector, stages two and three each resolve half of both quotients with a chain
// of restoring steps. Each stage holds its item when the stage after it is full
// and stalled, so a stall drops nothing. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_pixel (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [rthsv_pkg::IN_DATA_W-1:0]  s_tdata,  // red, green, blue
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [rthsv_pkg::OUT_DATA_W-1:0]      m_tdata   // hue, saturation, brightness, 0
);

  rthsv_pkg::rthsv_div_t front_out;
  rthsv_pkg::rthsv_div_t div1_out;
  rthsv_pkg::rthsv_div_t div2_out;
  rthsv_pkg::rthsv_div_t st1;
  rthsv_pkg::rthsv_div_t st2;
  logic                  v1;
  logic                  v2;
  logic                  v3;
  logic                  rdy1;
  logic                  rdy2;
  logic                  rdy3;
  logic [14:0]           hue;
  logic [12:0]           saturation;
  logic [7:0]            brightness;

  // A stage takes a new item when it is empty or its item moves on.
  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  rthsv_front u_front (
    .red      (s_tdata[7:0]),
    .green    (s_tdata[15:8]),
    .blue     (s_tdata[23:16]),
    .div_init (front_out)
  );

  rthsv_div_stage u_div1 (
    .div_in  (st1),
    .div_out (div1_out)
  );

  rthsv_div_stage u_div2 (
    .div_in  (st2),
    .div_out (div2_out)
  );

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Payload registers advance with their stage.
  always_ff @(posedge clk) begin
    if (rdy1) st1 <= front_out;
    if (rdy2) st2 <= div1_out;
    if (rdy3) begin
      hue        <= div2_out.zero ? 15'd0 : div2_out.hue_quo[14:0];
      saturation <= div2_out.zero ? 13'd0 : div2_out.sat_quo[12:0];
      brightness <= div2_out.bright;
    end
  end

  // Output channel.
  assign m_tvalid = v3;
  assign m_tdata  = {4'b0, brightness, saturation, hue};

endmodule

`default_nettype wire

[rtl/rthsv_checker.sv]
// ----------------------------------------------------------------------------
// RGB to HSV port checker
// Watches the top-level ports for output ranges and flow-control behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module rthsv_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [rthsv_pkg::OUT_DATA_W-1:0] m_tdata
);

  // A held output item keeps its value until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed while stalled");

  // Input is only refused when the whole pipeline is backed up.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input refused without output stall");

  // Hue stays below a full turn and saturation at most 1.0.
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[14:0] < 15'd23040) && (m_tdata[27:15] <= 13'd4096))
    else $error("hue or saturation out of range");

  // Black gives zero hue and saturation; the pad bits stay zero.
  a_black: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[35:28] == 8'd0) |->
      (m_tdata[27:0] == 28'd0) && (m_tdata[39:36] == 4'd0))
    else $error("black pixel gave nonzero hue or saturation");

endmodule

bind rgb_to_hsv_pixel rthsv_checker u_rthsv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Testbench for the RGB to HSV pixel converter
// A table of directed pixels covers black, grey, the primaries, the
// secondaries, ties for the largest channel and the wrap near 360 degrees.
// Random pixels follow in three phases of input and output idling. A long
// output hold fills the pipeline. Every result is compared field by field with
// the typed row's expectation or else with an integer model of the conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Fixed-point scales of the hue and saturation fields.
  localparam int DEG_UNITS    = 64;
  localparam int SECTOR_UNITS = 60 * DEG_UNITS;
  localparam int TURN_UNITS   = 360 * DEG_UNITS;
  localparam int SAT_ONE      = 4096;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASE_ITEMS  = 143;
  localparam int TABLE_ROWS   = 22;

  typedef struct packed {
    logic [14:0] hue;
    logic [12:0] sat;
    logic [7:0]  bright;
  } hsv_t;

  typedef struct packed {
    bit          typed;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    hsv_t        want;
  } pixel_row_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [rthsv_pkg::IN_DATA_W-1:0]  s_tdata;   // red, green, blue
  logic                             m_tvalid;
  logic                             m_tready;
  logic [rthsv_pkg::OUT_DATA_W-1:0] m_tdata;   // hue, saturation, brightness, pad

  hsv_t pending_hsv[$];
  int   mismatches;
  int   pixels_sent;
  int   results_seen;
  int   grey_pixels;
  int   cycle_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_len;
  int   sector_hits[rthsv_pkg::rthsv_sector_t];

  // Directed pixels; rows marked typed carry an expectation read off by hand.
  pixel_row_t pixel_table [TABLE_ROWS] = '{
    '{1'b1, 8'd0,   8'd0,   8'd0,   '{15'd0,     13'd0,    8'd0}},
    '{1'b1, 8'd255, 8'd255, 8'd255, '{15'd0,     13'd0,    8'd255}},
    '{1'b1, 8'd1,   8'd1,   8'd1,   '{15'd0,     13'd0,    8'd1}},
    '{1'b1, 8'd255, 8'd0,   8'd0,   '{15'd0,     13'd4096, 8'd255}},
    '{1'b1, 8'd0,   8'd255, 8'd0,   '{15'd7680,  13'd4096, 8'd255}},
    '{1'b1, 8'd0,   8'd0,   8'd255, '{15'd15360, 13'd4096, 8'd255}},
    '{1'b1, 8'd255, 8'd255, 8'd0,   '{15'd3840,  13'd4096, 8'd255}},
    '{1'b1, 8'd0,   8'd255, 8'd255, '{15'd11520, 13'd4096, 8'd255}},
    '{1'b1, 8'd255, 8'd0,   8'd255, '{15'd19200, 13'd4096, 8'd255}},
    '{1'b1, 8'd1,   8'd0,   8'd0,   '{15'd0,     13'd4096, 8'd1}},
    '{1'b0, 8'd255, 8'd0,   8'd1,   '0},
    '{1'b0, 8'd255, 8'd254, 8'd254, '0},
    '{1'b0, 8'd254, 8'd255, 8'd255, '0},
    '{1'b0, 8'd1,   8'd0,   8'd1,   '0},
    '{1'b0, 8'd0,   8'd1,   8'd1,   '0},
    '{1'b0, 8'd128, 8'd64,  8'd0,   '0},
    '{1'b0, 8'hAA,  8'h55,  8'hFF,  '0},
    '{1'b0, 8'h55,  8'hAA,  8'h00,  '0},
    '{1'b0, 8'd200, 8'd100, 8'd199, '0},
    '{1'b0, 8'd17,  8'd250, 8'd3,   '0},
    '{1'b0, 8'd2,   8'd1,   8'd0,   '0},
    '{1'b0, 8'd255, 8'd1,   8'd0,   '0}
  };

  rgb_to_hsv_pixel i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hexcone conversion in integers; also reports the sector that applied.
  function automatic hsv_t convert_pixel(input logic [7:0] red, input logic [7:0] green,
                                         input logic [7:0] blue,
                                         output rthsv_pkg::rthsv_sector_t sector);
    int   r;
    int   g;
    int   b;
    int   mx;
    int   mn;
    int   delta;
    int   num;
    hsv_t res;
    r = red;
    g = green;
    b = blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    res = '0;
    res.bright = mx[7:0];
    sector = rthsv_pkg::SEC_RED;
    if (mx != 0 && delta != 0) begin
      res.sat = 13'((delta * SAT_ONE) / mx);
      if (mx == r) begin
        num = SECTOR_UNITS * (g - b);
        if (num < 0) num += TURN_UNITS * delta;
      end else if (mx == g) begin
        sector = rthsv_pkg::SEC_GREEN;
        num = SECTOR_UNITS * (b - r) + 2 * SECTOR_UNITS * delta;
      end else begin
        sector = rthsv_pkg::SEC_BLUE;
        num = SECTOR_UNITS * (r - g) + 4 * SECTOR_UNITS * delta;
      end
      // The numerator is never negative here, so this is a floor.
      res.hue = 15'(num / delta);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want,
             cycle_count);
    mismatches++;
  endtask

  // Offers one pixel, starting and ending at a falling edge. The expectation
  // is queued at the rising edge where the pixel is taken.
  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input bit typed, input hsv_t typed_want);
    hsv_t                     want;
    rthsv_pkg::rthsv_sector_t sector;
    want = convert_pixel(red, green, blue, sector);
    if (typed) want = typed_want;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {blue, green, red};
    do @(posedge clk); while (!s_tready);
    pending_hsv.push_back(want);
    pixels_sent++;
    if (want.sat == 0) grey_pixels++;
    else sector_hits[sector]++;
    @(negedge clk);
  endtask

  // Random pixels, weighted toward greys, ties, extremes and tiny values.
  task automatic send_random_pixels(input int count);
    logic [7:0] ch [3];
    logic [7:0] top;
    int         odd;
    repeat (count) begin
      case ($urandom_range(9))
        0: begin
          top = 8'($urandom_range(255));
          ch = '{top, top, top};
        end
        1: begin
          top = 8'($urandom_range(255));
          odd = $urandom_range(2);
          foreach (ch[k]) ch[k] = (k == odd) ? 8'($urandom_range(top)) : top;
        end
        2: begin
          foreach (ch[k]) begin
            case ($urandom_range(3))
              0: ch[k] = 8'd0;
              1: ch[k] = 8'd1;
              2: ch[k] = 8'd254;
              default: ch[k] = 8'd255;
            endcase
          end
        end
        3: begin
          foreach (ch[k]) ch[k] = 8'($urandom_range(3));
        end
        default: begin
          foreach (ch[k]) ch[k] = 8'($urandom_range(255));
        end
      endcase
      send_pixel(ch[0], ch[1], ch[2], 1'b0, '0);
    end
  endtask

  // Drops the input and waits at falling edges until every result is back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_hsv.size() != 0) @(negedge clk);
  endtask

  // Output side: random backpressure, plus a long hold when one is requested.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_len > 0) begin
        m_tready <= 1'b0;
        hold_len--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    hsv_t got;
    hsv_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.hue    = m_tdata[14:0];
      got.sat    = m_tdata[27:15];
      got.bright = m_tdata[35:28];
      results_seen++;
      if (pending_hsv.size() == 0) begin
        report_mismatch("unexpected result, hue", got.hue, -1);
      end else begin
        want = pending_hsv.pop_front();
        if (got.hue != want.hue) report_mismatch("hue", got.hue, want.hue);
        if (got.sat != want.sat) report_mismatch("saturation", got.sat, want.sat);
        if (got.bright != want.bright) begin
          report_mismatch("brightness", got.bright, want.bright);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_hsv.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Stimulus and end of test.
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    mismatches = 0;
    pixels_sent = 0;
    results_seen = 0;
    grey_pixels = 0;
    hold_len = 0;
    send_idle_pct = 7;
    recv_idle_pct = 82;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase one: sparse input gaps, heavy output backpressure.
    foreach (pixel_table[i]) begin
      send_pixel(pixel_table[i].red, pixel_table[i].green, pixel_table[i].blue,
                 pixel_table[i].typed, pixel_table[i].want);
    end
    send_random_pixels(PHASE_ITEMS);
    drain_results();

    // Phase two: heavy input gaps, sparse backpressure.
    send_idle_pct = 82;
    recv_idle_pct = 7;
    send_random_pixels(PHASE_ITEMS);
    drain_results();

    // Phase three: full rate, with one long output hold mid-phase.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_pixels(PHASE_ITEMS / 3);
    hold_len = HOLD_CYCLES;
    send_random_pixels(PHASE_ITEMS - PHASE_ITEMS / 3);
    s_tvalid <= 1'b0;

    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d pixels, %0d results checked, %0d of them grey or black.",
             pixels_sent, results_seen, grey_pixels);
    $display("Hue sectors hit: red %0d, green %0d, blue %0d; mismatches %0d.",
             sector_hits[rthsv_pkg::SEC_RED], sector_hits[rthsv_pkg::SEC_GREEN],
             sector_hits[rthsv_pkg::SEC_BLUE], mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/rthsv_pkg.sv
rtl/rthsv_front.sv
rtl/rthsv_div_stage.sv
rtl/rgb_to_hsv_pixel.sv
rtl/rthsv_checker.sv
bench/tb.sv
